FILE: src/lir_pkg.sv
// Shared types and constants for the Lagrange interframe residual block.
// Holds the transaction payload structs, the multiply-accumulate control struct
// and the binomial coefficient table. Depends on nothing else.
package lir_pkg;

	// Widths fixed by the payload fields.
	localparam int COORD_W = 16;
	localparam int QB_W    = 5;
	localparam int CODE_W  = 18;
	localparam int ORDER_W = 4;

	// Binomial table covers every order up to sixteen frames.
	localparam int BINOM_N = 16;
	localparam int COEF_W  = 14;
	localparam int BIDX_W  = 4;

	typedef struct packed {
		logic [COORD_W-1:0] coord_value;
		logic [QB_W-1:0]    quant_bits;
		logic               last_in_frame;
	} in_item_t;

	typedef struct packed {
		logic signed [CODE_W-1:0] code_value;
		logic                     predicted;
		logic                     end_of_frame;
	} out_item_t;

	// Control from the sequencer to the shared multiply-accumulate unit.
	typedef struct packed {
		logic clear;
		logic load;
		logic neg;
		logic clamp;
	} mac_ctl_t;

	// Entry {n-1, j} holds C(n, j).
	typedef logic [BINOM_N*BINOM_N-1:0][COEF_W-1:0] binom_tab_t;

	// Builds the table row by row from Pascal's triangle at elaboration.
	function automatic binom_tab_t build_binom();
		binom_tab_t       t;
		logic [COEF_W-1:0] row [BINOM_N+1];
		int               n;
		int               j;
		t = '0;
		for (j = 0; j <= BINOM_N; j++) begin
			row[j] = '0;
		end
		row[0] = COEF_W'(1);
		for (n = 1; n <= BINOM_N; n++) begin
			for (j = n; j >= 1; j--) begin
				row[j] = row[j] + row[j-1];
			end
			for (j = 0; j < BINOM_N; j++) begin
				t[(n-1)*BINOM_N + j] = row[j];
			end
		end
		return t;
	endfunction

	localparam binom_tab_t BINOM_TAB = build_binom();

endpackage

FILE: src/lir_mac.sv
// Shared multiply-accumulate unit with the final clamp of the guess.
// One weighted history term is multiplied per cycle and added or subtracted.
// Depends on lir_pkg.
module lir_mac #(
	parameter int STORE_W    = 16,
	parameter int ACC_W      = 25,
	parameter int VALUE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lir_pkg::mac_ctl_t       ctl,
	input  logic [STORE_W-1:0]      rd_data,
	input  logic [lir_pkg::COEF_W-1:0] coef,
	input  logic [lir_pkg::QB_W-1:0]   quant_bits,
	output logic                    busy,
	output logic signed [ACC_W-1:0] acc
);
	import lir_pkg::*;

	localparam int PROD_W = STORE_W + COEF_W;

	logic [PROD_W-1:0]       prod_s2;
	logic                    neg_s2;
	logic                    vld_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] limit;
	logic [QB_W-1:0]         qb_sat;
	logic signed [ACC_W-1:0] clamped;

	// Multiply stage: one product per cycle, registered before accumulation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.load;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			prod_s2 <= PROD_W'(rd_data) * PROD_W'(coef);
			neg_s2  <= ctl.neg;
		end
	end

	// Clamp limit is two to the power of the saturated quantization bits.
	always_comb begin
		qb_sat = (quant_bits > QB_W'(VALUE_BITS)) ? QB_W'(VALUE_BITS) : quant_bits;
		limit  = {{(ACC_W-1){1'b0}}, 1'b1} << qb_sat;
		term   = $signed(ACC_W'(prod_s2));
		if (acc_q[ACC_W-1]) begin
			clamped = '0;
		end else if (acc_q > limit) begin
			clamped = limit;
		end else begin
			clamped = acc_q;
		end
	end

	// Accumulator: cleared per transaction, then summed, then clamped in place.
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= neg_s2 ? (acc_q - term) : (acc_q + term);
		end else if (ctl.clamp) begin
			acc_q <= clamped;
		end
	end

	assign busy = vld_s2;
	assign acc  = acc_q;

endmodule

FILE: src/lagrange_interframe_residual.sv
// Lagrange interframe residual coder: top level with sequencer and history memory.
// Depends on lir_pkg and lir_mac.
// Sequencing: a predicted coordinate passes through RUN, one history read per order
// step, then CLAMP and FIN; a warm-up coordinate goes straight to FIN. A new item is
// taken only in IDLE, after FIN. The history read port and the one multiplier serialize
// the reads. Reset clears the counters and sets order_q to 3; history is undefined.
module lagrange_interframe_residual #(
	parameter int MAX_ORDER  = 8,
	parameter int MAX_COORDS = 4096,
	parameter int VALUE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lir_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lir_pkg::out_item_t            out_item,
	input  logic                          cfg_wen,
	input  logic [lir_pkg::ORDER_W-1:0]   cfg_wdata
);
	import lir_pkg::*;

	localparam int SLOT_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int IDX_W   = $clog2(MAX_COORDS);
	localparam int CNT_W   = $clog2(MAX_ORDER + 1);
	localparam int STORE_W = (VALUE_BITS < COORD_W) ? VALUE_BITS : COORD_W;
	localparam int ACC_A   = STORE_W + MAX_ORDER + 1;
	localparam int ACC_B   = (VALUE_BITS + 2 > CODE_W) ? VALUE_BITS + 2 : CODE_W;
	localparam int ACC_W   = (ACC_A > ACC_B) ? ACC_A : ACC_B;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_CLAMP = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]           state_q;
	logic [ORDER_W-1:0]   order_q;
	in_item_t             item_q;
	logic [CNT_W-1:0]     k_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     frames_q;
	logic [SLOT_W-1:0]    oldest_q;
	logic [CNT_W-1:0]     rd_cnt_q;
	logic [SLOT_W-1:0]    rslot_q;
	logic                 pred_q;
	logic                 neg_iss_q;
	logic                 vld_s1;
	logic [COEF_W-1:0]    coef_s1;
	logic                 neg_s1;
	logic [STORE_W-1:0]   hist_rd_s1;
	logic                 out_valid_q;
	out_item_t            out_item_q;

	logic [STORE_W-1:0]   hist_mem [MAX_ORDER][MAX_COORDS];

	logic                 accept;
	logic                 issue;
	logic                 finish;
	logic [CNT_W-1:0]     k_eff;
	logic [CNT_W:0]       first_sum;
	logic [CNT_W:0]       wr_sum;
	logic [SLOT_W-1:0]    first_slot;
	logic [SLOT_W-1:0]    wr_slot;
	logic [STORE_W-1:0]   value;
	mac_ctl_t             mac_ctl;
	logic                 mac_busy;
	logic signed [ACC_W-1:0] mac_acc;
	logic signed [ACC_W-1:0] resid;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign issue    = (state_q == ST_RUN) && (rd_cnt_q != k_q);
	assign finish   = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign value    = item_q.coord_value[STORE_W-1:0];

	// Effective order: zero acts as one, large values saturate.
	always_comb begin
		if (order_q == '0) begin
			k_eff = CNT_W'(1);
		end else if ({1'b0, order_q} > (ORDER_W+1)'(MAX_ORDER)) begin
			k_eff = CNT_W'(MAX_ORDER);
		end else begin
			k_eff = CNT_W'(order_q);
		end
	end

	// Ring slots: oldest frame used for prediction and the slot being written.
	always_comb begin
		first_sum  = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(frames_q) - (CNT_W+1)'(k_eff);
		wr_sum     = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(frames_q);
		first_slot = (first_sum >= (CNT_W+1)'(MAX_ORDER))
			? SLOT_W'(first_sum - (CNT_W+1)'(MAX_ORDER)) : SLOT_W'(first_sum);
		wr_slot    = (wr_sum >= (CNT_W+1)'(MAX_ORDER))
			? SLOT_W'(wr_sum - (CNT_W+1)'(MAX_ORDER)) : SLOT_W'(wr_sum);
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_W'(3);
		end else if (cfg_wen) begin
			order_q <= cfg_wdata;
		end
	end

	// Sequencer and frame bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			frames_q  <= '0;
			oldest_q  <= '0;
			rd_cnt_q  <= '0;
			rslot_q   <= '0;
			k_q       <= '0;
			pred_q    <= 1'b0;
			neg_iss_q <= 1'b0;
			vld_s1    <= 1'b0;
		end else begin
			vld_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q       <= k_eff;
						pred_q    <= (frames_q >= k_eff);
						rd_cnt_q  <= '0;
						rslot_q   <= first_slot;
						neg_iss_q <= ~k_eff[0];
						state_q   <= (frames_q >= k_eff) ? ST_RUN : ST_FIN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						rd_cnt_q  <= rd_cnt_q + CNT_W'(1);
						neg_iss_q <= ~neg_iss_q;
						rslot_q   <= (rslot_q == SLOT_W'(MAX_ORDER - 1))
							? '0 : rslot_q + SLOT_W'(1);
					end else if (!vld_s1 && !mac_busy) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (item_q.last_in_frame) begin
							idx_q <= '0;
							if (frames_q < CNT_W'(MAX_ORDER)) begin
								frames_q <= frames_q + CNT_W'(1);
							end else begin
								oldest_q <= (oldest_q == SLOT_W'(MAX_ORDER - 1))
									? '0 : oldest_q + SLOT_W'(1);
							end
						end else begin
							idx_q <= (idx_q == IDX_W'(MAX_COORDS - 1))
								? '0 : idx_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latched transaction and per-read weight and sign.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
		if (issue) begin
			coef_s1 <= BINOM_TAB[{BIDX_W'(k_q - CNT_W'(1)), BIDX_W'(rd_cnt_q)}];
			neg_s1  <= neg_iss_q;
		end
	end

	// History memory: one read per cycle while summing, one write at the end.
	always_ff @(posedge clk) begin
		if (finish) begin
			hist_mem[wr_slot][idx_q] <= value;
		end
		if (issue) begin
			hist_rd_s1 <= hist_mem[rslot_q][idx_q];
		end
	end

	// Shared multiply-accumulate unit.
	always_comb begin
		mac_ctl.clear = accept;
		mac_ctl.load  = vld_s1;
		mac_ctl.neg   = neg_s1;
		mac_ctl.clamp = (state_q == ST_CLAMP);
	end

	lir_mac #(
		.STORE_W    (STORE_W),
		.ACC_W      (ACC_W),
		.VALUE_BITS (VALUE_BITS)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mac_ctl),
		.rd_data    (hist_rd_s1),
		.coef       (coef_s1),
		.quant_bits (item_q.quant_bits),
		.busy       (mac_busy),
		.acc        (mac_acc)
	);

	assign resid = mac_acc - $signed(ACC_W'(value));

	// Output register: holds a finished transaction until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_item_q.code_value   <= pred_q ? resid[CODE_W-1:0] : CODE_W'(value);
			out_item_q.predicted    <= pred_q;
			out_item_q.end_of_frame <= item_q.last_in_frame;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for lagrange_interframe_residual: streams coordinate frames
// through the block and compares every result with an in-bench Lagrange predictor.
// Depends on lir_pkg and the lagrange_interframe_residual RTL.
module tb_top;
	import lir_pkg::*;

	localparam int MAX_ORDER    = 8;
	localparam int MAX_COORDS   = 4096;
	localparam int VALUE_BITS   = 16;
	localparam int LIMIT_CYCLES = 800000;
	localparam int PHASE_ITEMS  = 80;
	localparam int TRACKS       = 64;

	// Predicts the residual stream and holds the results still owed by the block.
	class residual_predictor;
		logic [ORDER_W-1:0]    order_reg;
		logic [COORD_W-1:0]    hist [MAX_ORDER][MAX_COORDS];
		bit                    seen [MAX_ORDER][MAX_COORDS];
		int unsigned           coord_idx;
		int unsigned           held;
		int unsigned           oldest;
		out_item_t             pending_codes[$];
		int                    errors;

		function new();
			order_reg = ORDER_W'(3);
			coord_idx = 0;
			held      = 0;
			oldest    = 0;
			errors    = 0;
		endfunction

		function void set_order(logic [ORDER_W-1:0] v);
			order_reg = v;
		endfunction

		// Order zero acts as one and anything above the ring depth saturates.
		function int unsigned eff_order();
			if (order_reg == 0) return 1;
			if (order_reg > MAX_ORDER) return MAX_ORDER;
			return order_reg;
		endfunction

		// True when predicting coordinate idx now reads only history that was written.
		function bit entry_ready(int unsigned idx);
			int unsigned k;
			int unsigned first;
			int unsigned j;
			k = eff_order();
			if (held < k) return 1'b1;
			first = (oldest + held - k) % MAX_ORDER;
			for (j = 0; j < k; j++) begin
				if (!seen[(first + j) % MAX_ORDER][idx]) return 1'b0;
			end
			return 1'b1;
		endfunction

		// Weighted sum with signed binomial weights, oldest frame first.
		function longint extrapolate_guess(int unsigned k, int unsigned idx);
			longint      sum;
			longint      binom;
			longint      v;
			int unsigned first;
			int unsigned j;
			sum   = 0;
			binom = 1;
			first = (oldest + held - k) % MAX_ORDER;
			for (j = 0; j < k; j++) begin
				v = longint'(hist[(first + j) % MAX_ORDER][idx]);
				if (((k - 1 - j) & 1) != 0) sum -= binom * v;
				else sum += binom * v;
				binom = binom * longint'(k - j) / longint'(j + 1);
			end
			return sum;
		endfunction

		// Runs one accepted coordinate through the prediction and queues its result.
		function void note_coord(in_item_t it);
			int unsigned k;
			int unsigned qb;
			int unsigned wslot;
			longint      guess;
			longint      limit;
			longint      code;
			out_item_t   r;
			k     = eff_order();
			qb    = it.quant_bits;
			wslot = (oldest + held) % MAX_ORDER;
			if (qb > VALUE_BITS) qb = VALUE_BITS;
			if (held >= k) begin
				limit = longint'(1) << qb;
				guess = extrapolate_guess(k, coord_idx);
				if (guess < 0) guess = 0;
				if (guess > limit) guess = limit;
				code = guess - longint'(it.coord_value);
				r.predicted = 1'b1;
			end else begin
				code = longint'(it.coord_value);
				r.predicted = 1'b0;
			end
			r.code_value   = code[CODE_W-1:0];
			r.end_of_frame = it.last_in_frame;
			pending_codes.insert(pending_codes.size(), r);

			hist[wslot][coord_idx] = it.coord_value;
			seen[wslot][coord_idx] = 1'b1;
			if (it.last_in_frame) begin
				coord_idx = 0;
				if (held < MAX_ORDER) held++;
				else oldest = (oldest + 1) % MAX_ORDER;
			end else begin
				coord_idx = (coord_idx + 1) % MAX_COORDS;
			end
		endfunction

		// Compares one result with the oldest owed result, field by field.
		function void check_code(out_item_t got);
			out_item_t want;
			if (pending_codes.size() == 0) begin
				$display("%0t: unexpected result code_value %0d", $time,
					$signed(got.code_value));
				errors++;
				return;
			end
			want = pending_codes[0];
			pending_codes.delete(0);
			if (got.code_value !== want.code_value) begin
				$display("%0t: code_value expected %0d actual %0d", $time,
					$signed(want.code_value), $signed(got.code_value));
				errors++;
			end
			if (got.predicted !== want.predicted) begin
				$display("%0t: predicted expected %0b actual %0b", $time,
					want.predicted, got.predicted);
				errors++;
			end
			if (got.end_of_frame !== want.end_of_frame) begin
				$display("%0t: end_of_frame expected %0b actual %0b", $time,
					want.end_of_frame, got.end_of_frame);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	in_item_t           in_item   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_item_t          out_item;
	logic               cfg_wen   = 1'b0;
	logic [ORDER_W-1:0] cfg_wdata = '0;

	residual_predictor  board = new();
	bit                 steady = 1'b0;
	int                 cycles = 0;
	int                 trk_pos [TRACKS];
	int                 trk_vel [TRACKS];
	logic [QB_W-1:0]    qb_axis [3];

	lagrange_interframe_residual #(
		.MAX_ORDER (MAX_ORDER),
		.MAX_COORDS(MAX_COORDS),
		.VALUE_BITS(VALUE_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Result side: check each accepted transaction and stall at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_code(out_item);
		out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 10);
	end

	// Offers one coordinate, waits for its acceptance and sometimes idles afterward.
	task automatic send_coord(input in_item_t it);
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		board.note_coord(it);
		if (!steady && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic send_fixed(input int v, input int qb, input bit last);
		in_item_t it;
		it.coord_value   = COORD_W'(v);
		it.quant_bits    = QB_W'(qb);
		it.last_in_frame = last;
		send_coord(it);
	endtask

	// Drains the block so that the order register can be rewritten safely.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_codes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_order(input logic [ORDER_W-1:0] v);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		board.set_order(v);
	endtask

	// Fresh trajectories and axis resolutions for a new phase.
	task automatic init_tracks();
		int t;
		int lim;
		for (t = 0; t < 3; t++) begin
			if ($urandom_range(0, 7) == 0) qb_axis[t] = QB_W'($urandom_range(17, 31));
			else qb_axis[t] = QB_W'($urandom_range(0, 16));
		end
		for (t = 0; t < TRACKS; t++) begin
			lim = (qb_axis[t % 3] > VALUE_BITS) ? VALUE_BITS : int'(qb_axis[t % 3]);
			trk_pos[t] = int'($urandom_range(0, (1 << lim) - 1));
			trk_vel[t] = int'($urandom_range(0, 40)) - 20;
		end
	endtask

	// One frame of up to len coordinates. The frame is closed early wherever the
	// next coordinate would be predicted from history that was never written.
	task automatic run_frame(input int len, input bit smooth, output int sent);
		in_item_t    it;
		int unsigned idx;
		int          t;
		int          v;
		int          i;
		bit          last;
		sent = 0;
		for (i = 0; i < len; i++) begin
			idx = board.coord_idx;
			if (smooth) begin
				t = idx % TRACKS;
				trk_vel[t] = trk_vel[t] + int'($urandom_range(0, 2)) - 1;
				v = trk_pos[t] + trk_vel[t] + int'($urandom_range(0, 4)) - 2;
				if (v < 0) v = 0;
				if (v > 65535) v = 65535;
				trk_pos[t] = v;
				it.coord_value = COORD_W'(v);
				it.quant_bits  = qb_axis[idx % 3];
			end else begin
				it.coord_value = COORD_W'($urandom);
				it.quant_bits  = QB_W'($urandom_range(0, 31));
			end
			last = (i == len - 1);
			if (!last && !board.entry_ready((idx + 1) % MAX_COORDS)) last = 1'b1;
			it.last_in_frame = last;
			send_coord(it);
			sent++;
			if (last) break;
		end
	endtask

	initial begin
		logic [ORDER_W-1:0] orders [10];
		int                 p;
		int                 count;
		int                 base_len;
		int                 len;
		int                 sent;
		bit                 smooth;

		orders = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd2, 4'd3, 4'd7, 4'd4, 4'd6};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Three warm-up frames with extreme values.
		send_fixed(0, 16, 1'b0);
		send_fixed(65535, 16, 1'b0);
		send_fixed(5, 0, 1'b1);
		send_fixed(65535, 16, 1'b0);
		send_fixed(0, 16, 1'b0);
		send_fixed(3, 0, 1'b1);
		send_fixed(0, 16, 1'b0);
		send_fixed(65535, 16, 1'b0);
		send_fixed(2, 0, 1'b1);

		// Predicted frames: negative estimate, estimate above the limit,
		// a zero-bit limit, and quant_bits beyond the value width.
		send_fixed(65535, 16, 1'b0);
		send_fixed(0, 16, 1'b0);
		send_fixed(1, 0, 1'b1);
		send_fixed(32768, 16, 1'b0);
		send_fixed(40000, 31, 1'b0);
		send_fixed(0, 31, 1'b1);
		send_fixed(12345, 17, 1'b0);
		send_fixed(65535, 20, 1'b0);
		send_fixed(65535, 16, 1'b1);

		// Random phases, one order setting each; the first raises the order
		// above the frames held so warm-up resumes.
		for (p = 0; p < 10; p++) begin
			wait_idle();
			write_order(orders[p]);
			steady = (p == 3);
			init_tracks();
			base_len = 3 * int'($urandom_range(1, 5));
			count = 0;
			while (count < PHASE_ITEMS) begin
				smooth = ($urandom_range(0, 99) < 85);
				if (!smooth || $urandom_range(0, 4) == 0) len = int'($urandom_range(1, 24));
				else len = base_len;
				run_frame(len, smooth, sent);
				count += sent;
			end
		end
		steady = 1'b0;

		wait_idle();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending_codes.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/lir_pkg.sv
src/lir_mac.sv
src/lagrange_interframe_residual.sv
tb/tb_top.sv
